[src/modexp_pkg.sv]
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared widths and the sequencer state type of the modular exponentiation
// block.
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int ROOT_BITS = 16;
  localparam int EXP_BITS  = 32;
  localparam int DATA_BITS = 32;
  localparam int CFG_BITS  = 16;

  // The modulus (root squared) is twice the root width; residue products double it.
  localparam int MOD_BITS  = 2 * ROOT_BITS;
  localparam int PROD_BITS = 2 * MOD_BITS;

  // The reducer takes either a product of residues or the raw base.
  localparam int RED_BITS  = (PROD_BITS > DATA_BITS) ? PROD_BITS : DATA_BITS;
  localparam int RED_CNT_BITS = $clog2(RED_BITS + 1);

  localparam int BIT_CNT_BITS = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

  localparam int IN_TDATA_BITS  = ((DATA_BITS + EXP_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((DATA_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT_SQ,
    ST_BASE_RED,
    ST_BIT,
    ST_ACC_RED,
    ST_SQ_RED,
    ST_DONE
  } state_t;

endpackage

[src/modexp_reduce.sv]
// ----------------------------------------------------------------------------
// modexp_reduce
// Bit-serial restoring reduction of a wide operand modulo a variable modulus,
// one operand bit per cycle.
// ----------------------------------------------------------------------------
module modexp_reduce (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [modexp_pkg::RED_BITS-1:0]     operand,
  input  logic [modexp_pkg::MOD_BITS-1:0]     modulus,
  output logic                                done,
  output logic [modexp_pkg::MOD_BITS-1:0]     result
);

  logic [modexp_pkg::RED_BITS-1:0]     dividend;
  logic [modexp_pkg::MOD_BITS-1:0]     rem;
  logic [modexp_pkg::RED_CNT_BITS-1:0] cnt;

  logic [modexp_pkg::MOD_BITS:0] shifted;
  logic [modexp_pkg::MOD_BITS:0] diff;
  logic [modexp_pkg::MOD_BITS-1:0] rem_next;

  // The partial remainder stays below the modulus, so one subtraction per
  // step is enough to bring it back into range.
  always_comb begin
    shifted = {rem, dividend[modexp_pkg::RED_BITS-1]};
    diff    = shifted - {1'b0, modulus};
    if (shifted >= {1'b0, modulus}) begin
      rem_next = diff[modexp_pkg::MOD_BITS-1:0];
    end else begin
      rem_next = shifted[modexp_pkg::MOD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= modexp_pkg::RED_CNT_BITS'(modexp_pkg::RED_BITS);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == modexp_pkg::RED_CNT_BITS'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= operand;
      rem      <= '0;
    end else if (cnt != '0) begin
      dividend <= {dividend[modexp_pkg::RED_BITS-2:0], 1'b0};
      rem      <= rem_next;
    end
  end

  assign result = rem;

endmodule

[src/modular_exponentiation_mod_n_squared.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation_mod_n_squared
// Raises a base to an exponent modulo the square of a configured root n.
// ----------------------------------------------------------------------------
// Usage:
//   The cfg channel writes the root n (reset value 1, zero acts as 1). It is
//   always ready and should only be written while the block is idle.
//   An input item on s_axis carries the base and the exponent; one result
//   item leaves on m_axis for every input item.
//   An exponent of zero returns 1 and an exponent of one returns the base
//   unreduced; the sequencer goes straight to its done state for both.
//   Other exponents run square-and-multiply over all exponent bits, low bit
//   first. Every reduction goes through one bit-serial reducer, which shifts
//   through all 64 operand bits and then reports. The sequencer first forms
//   n*n and reduces the base, then for each exponent bit multiplies the
//   accumulator in if the bit is set and squares below the top bit, and
//   finishes in the done state, which loads the output register.
//   The block takes one item at a time; s_axis_tready is high only while it
//   is idle, from the cycle in which each result becomes valid. The result sits
//   in an output register; if it is still full when the next result is
//   ready, the sequencer holds until m_axis_tready frees it.
//   Reset empties the output register and restores the root to 1.
// ----------------------------------------------------------------------------
module modular_exponentiation_mod_n_squared (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [modexp_pkg::CFG_BITS-1:0]       cfg_data,      // key_root
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [modexp_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,  // base_value, power
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [modexp_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata   // result_value
);

  modexp_pkg::state_t state, state_next;

  logic [modexp_pkg::ROOT_BITS-1:0]    key_root;
  logic [modexp_pkg::ROOT_BITS-1:0]    root_eff;
  logic [modexp_pkg::DATA_BITS-1:0]    base;
  logic [modexp_pkg::EXP_BITS-1:0]     expo;
  logic [modexp_pkg::BIT_CNT_BITS-1:0] bit_cnt;
  logic [modexp_pkg::MOD_BITS-1:0]     modulus;
  logic [modexp_pkg::MOD_BITS-1:0]     acc;
  logic [modexp_pkg::MOD_BITS-1:0]     sq;
  logic [modexp_pkg::DATA_BITS-1:0]    res;
  logic                                out_valid;
  logic [modexp_pkg::DATA_BITS-1:0]    out_data;

  logic [modexp_pkg::DATA_BITS-1:0]    in_base;
  logic [modexp_pkg::EXP_BITS-1:0]     in_power;
  logic                                in_fire;
  logic                                out_free;
  logic                                last_bit;

  logic [modexp_pkg::MOD_BITS-1:0]     mul_a;
  logic [modexp_pkg::MOD_BITS-1:0]     mul_b;
  logic [modexp_pkg::PROD_BITS-1:0]    prod;
  logic                                red_start;
  logic [modexp_pkg::RED_BITS-1:0]     red_operand;
  logic                                red_done;
  logic [modexp_pkg::MOD_BITS-1:0]     red_result;

  assign in_base  = s_axis_tdata[modexp_pkg::DATA_BITS-1:0];
  assign in_power = s_axis_tdata[modexp_pkg::DATA_BITS +: modexp_pkg::EXP_BITS];
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid || m_axis_tready;
  assign last_bit = (bit_cnt == modexp_pkg::BIT_CNT_BITS'(modexp_pkg::EXP_BITS - 1));
  assign root_eff = (key_root == '0) ? modexp_pkg::ROOT_BITS'(1) : key_root;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == modexp_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = modexp_pkg::OUT_TDATA_BITS'(out_data);

  // The one multiplier; its product is registered as the modulus or in the reducer.
  assign prod = mul_a * mul_b;

  modexp_reduce u_reduce (
    .clk     (clk),
    .rst     (rst),
    .start   (red_start),
    .operand (red_operand),
    .modulus (modulus),
    .done    (red_done),
    .result  (red_result)
  );

  always_comb begin
    state_next = state;
    case (state)
      modexp_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_power == '0 || in_power == modexp_pkg::EXP_BITS'(1)) begin
            state_next = modexp_pkg::ST_DONE;
          end else begin
            state_next = modexp_pkg::ST_ROOT_SQ;
          end
        end
      end
      modexp_pkg::ST_ROOT_SQ: state_next = modexp_pkg::ST_BASE_RED;
      modexp_pkg::ST_BASE_RED: begin
        if (red_done) state_next = modexp_pkg::ST_BIT;
      end
      modexp_pkg::ST_BIT: begin
        if (expo[0]) begin
          state_next = modexp_pkg::ST_ACC_RED;
        end else if (last_bit) begin
          state_next = modexp_pkg::ST_DONE;
        end else begin
          state_next = modexp_pkg::ST_SQ_RED;
        end
      end
      modexp_pkg::ST_ACC_RED: begin
        if (red_done) begin
          state_next = last_bit ? modexp_pkg::ST_DONE : modexp_pkg::ST_SQ_RED;
        end
      end
      modexp_pkg::ST_SQ_RED: begin
        if (red_done) state_next = modexp_pkg::ST_BIT;
      end
      modexp_pkg::ST_DONE: begin
        if (out_free) state_next = modexp_pkg::ST_IDLE;
      end
      default: state_next = modexp_pkg::ST_IDLE;
    endcase
  end

  // Multiplier operands and reducer start for each step.
  always_comb begin
    mul_a       = sq;
    mul_b       = sq;
    red_start   = 1'b0;
    red_operand = modexp_pkg::RED_BITS'(prod);
    case (state)
      modexp_pkg::ST_ROOT_SQ: begin
        mul_a       = modexp_pkg::MOD_BITS'(root_eff);
        mul_b       = modexp_pkg::MOD_BITS'(root_eff);
        red_start   = 1'b1;
        red_operand = modexp_pkg::RED_BITS'(base);
      end
      modexp_pkg::ST_BIT: begin
        mul_a     = expo[0] ? acc : sq;
        red_start = expo[0] || !last_bit;
      end
      modexp_pkg::ST_ACC_RED: begin
        red_start = red_done && !last_bit;
      end
      default: begin
        red_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= modexp_pkg::ST_IDLE;
      key_root  <= modexp_pkg::ROOT_BITS'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        key_root <= cfg_data[modexp_pkg::ROOT_BITS-1:0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (state == modexp_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      modexp_pkg::ST_IDLE: begin
        if (in_fire) begin
          base    <= in_base;
          expo    <= in_power;
          bit_cnt <= '0;
          res     <= (in_power == '0) ? modexp_pkg::DATA_BITS'(1) : in_base;
        end
      end
      modexp_pkg::ST_ROOT_SQ: begin
        modulus <= prod[modexp_pkg::MOD_BITS-1:0];
      end
      modexp_pkg::ST_BASE_RED: begin
        if (red_done) begin
          sq  <= red_result;
          acc <= (modulus == modexp_pkg::MOD_BITS'(1)) ? '0 : modexp_pkg::MOD_BITS'(1);
        end
      end
      modexp_pkg::ST_BIT: begin
        if (!expo[0] && last_bit) begin
          res <= modexp_pkg::DATA_BITS'(acc);
        end
      end
      modexp_pkg::ST_ACC_RED: begin
        if (red_done) begin
          acc <= red_result;
          res <= modexp_pkg::DATA_BITS'(red_result);
        end
      end
      modexp_pkg::ST_SQ_RED: begin
        if (red_done) begin
          sq      <= red_result;
          expo    <= expo >> 1;
          bit_cnt <= bit_cnt + 1'b1;
        end
      end
      modexp_pkg::ST_DONE: begin
        if (out_free) begin
          out_data <= res;
        end
      end
      default: begin
        res <= res;
      end
    endcase
  end

`ifndef SYNTH
  a_done_only_when_waiting: assert property (@(posedge clk) disable iff (rst)
    red_done |-> (state == modexp_pkg::ST_BASE_RED || state == modexp_pkg::ST_ACC_RED ||
                  state == modexp_pkg::ST_SQ_RED))
    else $error("reducer finished outside a wait state");

  a_modulus_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == modexp_pkg::ST_BIT |-> modulus != '0)
    else $error("modulus is zero during the exponent loop");

  a_residues_reduced: assert property (@(posedge clk) disable iff (rst)
    state == modexp_pkg::ST_BIT |-> (acc < modulus || modulus == modexp_pkg::MOD_BITS'(1))
                                    && sq < modulus)
    else $error("accumulator or square not reduced");

  a_general_power_starts: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_power != '0 && in_power != modexp_pkg::EXP_BITS'(1)
    |=> state == modexp_pkg::ST_ROOT_SQ)
    else $error("general exponent did not start the sequencer");
`endif

endmodule
